// ----- hw/rtl/bvm_pkg.sv -----
// Battery voltage monitor package: widths, correction coefficients, FSM types.
// Used by every module of the monitor; depends on nothing.
package bvm_pkg;

	localparam int SAMPLE_W    = 12;
	localparam int MV_W        = 13;
	localparam int ACC_W       = 56;
	localparam int FRAC        = 48;
	localparam int WINDOW      = 6;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;
	localparam int HORNER_STEPS = 4;
	localparam int STEP_W      = 2;

	localparam logic [MV_W-1:0]   MV_MAX        = 13'd8191;
	localparam logic [MV_W-1:0]   THRESH_RESET  = 13'd3000;
	localparam logic [MV_W:0]     WARN_MARGIN   = 14'd500;
	localparam logic [63:0]       DEC_DEN       = 64'd1000000000000000;

	// round(num * 2^shift / 10^15), ties up; num is below 10^15
	function automatic logic [63:0] scaled_coef(input logic [63:0] num, input int shift);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = num;
		for (int i = 0; i < shift; i++) begin
			q = q << 1;
			r = r << 1;
			if (r >= DEC_DEN) begin
				r = r - DEC_DEN;
				q = q + 64'd1;
			end
		end
		if ((r << 1) >= DEC_DEN) begin
			q = q + 64'd1;
		end
		return q;
	endfunction

	localparam logic [63:0] D0_U = scaled_coef(64'd34143524634089, FRAC);
	localparam logic [63:0] D1_U = scaled_coef(64'd1109019271794, FRAC + 12);
	localparam logic [63:0] D2_U = scaled_coef(64'd301211691, FRAC + 24);
	localparam logic [63:0] D3_U = scaled_coef(64'd118171, FRAC + 36);
	localparam logic [63:0] D4_U = scaled_coef(64'd16, FRAC + 48);

	localparam logic signed [ACC_W-1:0] D0 = $signed(D0_U[ACC_W-1:0]);
	localparam logic signed [ACC_W-1:0] D1 = $signed(D1_U[ACC_W-1:0]);
	localparam logic signed [ACC_W-1:0] D2 = $signed(D2_U[ACC_W-1:0]);
	localparam logic signed [ACC_W-1:0] D3 = $signed(D3_U[ACC_W-1:0]);
	localparam logic signed [ACC_W-1:0] D4 = $signed(D4_U[ACC_W-1:0]);

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL,
		F_ADD,
		F_SCALE,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_WRITE,
		B_PREP,
		B_DIV,
		B_DONE
	} back_state_t;

endpackage

// ----- hw/rtl/battery_voltage_monitor_top.sv -----
// Battery voltage monitor, top level: front end, reading queue, back end and
// threshold register. Depends on bvm_pkg, bvm_front, bvm_fifo, bvm_back.
//
// Each accepted ADC sample yields exactly one result. The front end holds one
// sample through four Horner iterations of the shared 44x12 multiplier
// (multiply, then add), a scaling step and a queue transfer, and takes no new
// sample before it is done. The back end writes each reading into the ring and
// then finds the mean with a bit-serial divider before it takes the next one.
// The queue of two readings and the output register let each side stall on
// its own. The ring is cleared by reset; no sweep is needed. The threshold
// register resets to 3000 mV and is written by a transfer on the cfg channel.
module battery_voltage_monitor_top #(
	parameter int WINDOW = bvm_pkg::WINDOW
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [bvm_pkg::SAMPLE_W-1:0] adc_sample,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [bvm_pkg::MV_W-1:0]     average_mv,
	output logic                         warn,
	output logic                         sleep_request,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [bvm_pkg::MV_W-1:0]     low_threshold_mv
);

	logic                     push;
	logic [bvm_pkg::MV_W-1:0] push_mv;
	logic                     q_full;
	logic                     q_empty;
	logic                     pop;
	logic [bvm_pkg::MV_W-1:0] head_mv;
	logic [bvm_pkg::MV_W-1:0] thresh_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= bvm_pkg::THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thresh_q <= low_threshold_mv;
		end
	end

	bvm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.adc_sample (adc_sample),
		.push       (push),
		.push_mv    (push_mv),
		.q_full     (q_full)
	);

	bvm_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_mv (push_mv),
		.full    (q_full),
		.pop     (pop),
		.empty   (q_empty),
		.head_mv (head_mv)
	);

	bvm_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.empty         (q_empty),
		.head_mv       (head_mv),
		.pop           (pop),
		.threshold     (thresh_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.average_mv    (average_mv),
		.warn          (warn),
		.sleep_request (sleep_request)
	);

endmodule

// ----- hw/rtl/bvm_front.sv -----
// Front end: takes a raw sample, runs the Horner correction polynomial and
// scales to clamped millivolts. Depends on bvm_pkg.
module bvm_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [bvm_pkg::SAMPLE_W-1:0] adc_sample,
	output logic                        push,
	output logic [bvm_pkg::MV_W-1:0]    push_mv,
	input  logic                        q_full
);

	localparam int AW = bvm_pkg::ACC_W;
	localparam int HI_W = AW - 12;
	localparam int WH_W = AW + 11 - bvm_pkg::FRAC;
	localparam logic [bvm_pkg::STEP_W-1:0] STEP_W_LAST =
		bvm_pkg::STEP_W'(bvm_pkg::HORNER_STEPS - 1);

	bvm_pkg::front_state_t state_q, state_d;

	logic [bvm_pkg::SAMPLE_W-1:0] x_q;
	logic signed [AW-1:0]         acc_q;
	logic [AW-1:0]                prod_q;
	logic                         neg_q;
	logic [bvm_pkg::STEP_W-1:0]   step_q;
	logic [bvm_pkg::MV_W-1:0]     mv_q;

	logic                         accept;
	logic [AW-1:0]                mag;
	logic [AW-1:0]                p_hi;
	logic [23:0]                  p_lo;
	logic [AW-1:0]                prod;
	logic signed [AW-1:0]         coef;
	logic signed [AW-1:0]         term;
	logic [AW+10:0]               scaled;
	logic [WH_W-1:0]              whole;
	logic [bvm_pkg::MV_W-1:0]     mv;

	assign accept = in_valid && !in_stall;
	assign mag    = acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q);
	assign p_hi   = AW'(mag[AW-1:12] * HI_W'(x_q));
	assign p_lo   = mag[11:0] * x_q;
	assign prod   = p_hi + AW'(p_lo[23:12]);
	assign term   = neg_q ? -$signed(prod_q) : $signed(prod_q);

	always_comb begin
		unique case (step_q)
			2'd0:    coef = bvm_pkg::D3;
			2'd1:    coef = -bvm_pkg::D2;
			2'd2:    coef = bvm_pkg::D1;
			default: coef = bvm_pkg::D0;
		endcase
	end

	// acc * 2000 = acc * (2048 - 32 - 16)
	assign scaled = ({11'd0, acc_q} << 11) - ({11'd0, acc_q} << 5) - ({11'd0, acc_q} << 4);
	assign whole  = scaled[AW+10:bvm_pkg::FRAC];

	always_comb begin
		if (acc_q[AW-1] || acc_q == '0) begin
			mv = '0;
		end else if (whole > WH_W'(bvm_pkg::MV_MAX)) begin
			mv = bvm_pkg::MV_MAX;
		end else begin
			mv = whole[bvm_pkg::MV_W-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bvm_pkg::F_IDLE:  if (in_valid) state_d = bvm_pkg::F_MUL;
			bvm_pkg::F_MUL:   state_d = bvm_pkg::F_ADD;
			bvm_pkg::F_ADD: begin
				if (step_q == STEP_W_LAST) state_d = bvm_pkg::F_SCALE;
				else state_d = bvm_pkg::F_MUL;
			end
			bvm_pkg::F_SCALE: state_d = bvm_pkg::F_PUSH;
			bvm_pkg::F_PUSH:  if (!q_full) state_d = bvm_pkg::F_IDLE;
			default:          state_d = bvm_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != bvm_pkg::F_IDLE);
		push     = (state_q == bvm_pkg::F_PUSH) && !q_full;
	end

	assign push_mv = mv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bvm_pkg::F_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= '0;
			end else if (state_q == bvm_pkg::F_ADD) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= adc_sample;
			acc_q <= -bvm_pkg::D4;
		end
		if (state_q == bvm_pkg::F_MUL) begin
			prod_q <= prod;
			neg_q  <= acc_q[AW-1];
		end
		if (state_q == bvm_pkg::F_ADD) begin
			acc_q <= term + coef;
		end
		if (state_q == bvm_pkg::F_SCALE) begin
			mv_q <= mv;
		end
	end

endmodule

// ----- hw/rtl/bvm_fifo.sv -----
// Two-entry queue of millivolt readings between front and back end.
// Depends on bvm_pkg.
module bvm_fifo (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic [bvm_pkg::MV_W-1:0] push_mv,
	output logic                     full,
	input  logic                     pop,
	output logic                     empty,
	output logic [bvm_pkg::MV_W-1:0] head_mv
);

	logic [bvm_pkg::MV_W-1:0]   mem_q [bvm_pkg::QDEPTH];
	logic [bvm_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [bvm_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [bvm_pkg::QCNT_W-1:0] cnt_q;

	assign full    = (cnt_q == bvm_pkg::QCNT_W'(bvm_pkg::QDEPTH));
	assign empty   = (cnt_q == '0);
	assign head_mv = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_mv;
	end

endmodule

// ----- hw/rtl/bvm_back.sv -----
// Back end: ring of readings with running sum and non-zero count, serial
// divider for the mean, threshold compare and output register. Depends on bvm_pkg.
module bvm_back #(
	parameter int WINDOW = bvm_pkg::WINDOW
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     empty,
	input  logic [bvm_pkg::MV_W-1:0] head_mv,
	output logic                     pop,
	input  logic [bvm_pkg::MV_W-1:0] threshold,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [bvm_pkg::MV_W-1:0] average_mv,
	output logic                     warn,
	output logic                     sleep_request
);

	localparam int MW    = bvm_pkg::MV_W;
	localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W = $clog2(WINDOW * 8191 + 1);
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int DC_W  = $clog2(SUM_W + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

	bvm_pkg::back_state_t state_q, state_d;

	logic [MW-1:0]    ring_q [WINDOW];
	logic [IDX_W-1:0] widx_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MW-1:0]    mv_q;
	logic [SUM_W-1:0] quot_q;
	logic [CNT_W:0]   rem_q;
	logic [DC_W-1:0]  dcnt_q;
	logic             out_valid_q;
	logic [MW-1:0]    avg_q;
	logic             warn_q;
	logic             sleep_q;

	logic [MW-1:0]    old_mv;
	logic [CNT_W+1:0] trial;
	logic             load_out;
	logic [MW-1:0]    mean;
	logic [MW:0]      warn_lim;

	assign old_mv   = ring_q[widx_q];
	assign trial    = {rem_q, quot_q[SUM_W-1]} - {2'b00, cnt_q};
	assign mean     = (cnt_q == '0) ? '0 : quot_q[MW-1:0];
	assign warn_lim = {1'b0, threshold} + bvm_pkg::WARN_MARGIN;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bvm_pkg::B_IDLE:  if (!empty) state_d = bvm_pkg::B_WRITE;
			bvm_pkg::B_WRITE: state_d = bvm_pkg::B_PREP;
			bvm_pkg::B_PREP:  state_d = bvm_pkg::B_DIV;
			bvm_pkg::B_DIV:   if (dcnt_q == DC_W'(1)) state_d = bvm_pkg::B_DONE;
			bvm_pkg::B_DONE:  if (!out_valid_q || !out_stall) state_d = bvm_pkg::B_IDLE;
			default:          state_d = bvm_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		pop      = (state_q == bvm_pkg::B_IDLE) && !empty;
		load_out = (state_q == bvm_pkg::B_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bvm_pkg::B_IDLE;
			widx_q      <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < WINDOW; i++) ring_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == bvm_pkg::B_WRITE) begin
				ring_q[widx_q] <= mv_q;
				sum_q <= sum_q - SUM_W'(old_mv) + SUM_W'(mv_q);
				cnt_q <= cnt_q + CNT_W'(mv_q != '0) - CNT_W'(old_mv != '0);
				widx_q <= (widx_q == IDX_LAST) ? '0 : widx_q + 1'b1;
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) mv_q <= head_mv;
		if (state_q == bvm_pkg::B_PREP) begin
			quot_q <= sum_q;
			rem_q  <= '0;
			dcnt_q <= DC_W'(SUM_W);
		end
		if (state_q == bvm_pkg::B_DIV) begin
			dcnt_q <= dcnt_q - 1'b1;
			if (!trial[CNT_W+1]) begin
				rem_q  <= trial[CNT_W:0];
				quot_q <= {quot_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[CNT_W-1:0], quot_q[SUM_W-1]};
				quot_q <= {quot_q[SUM_W-2:0], 1'b0};
			end
		end
		if (load_out) begin
			avg_q   <= mean;
			warn_q  <= ({1'b0, mean} <= warn_lim);
			sleep_q <= (mean <= threshold);
		end
	end

	assign out_valid     = out_valid_q;
	assign average_mv    = avg_q;
	assign warn          = warn_q;
	assign sleep_request = sleep_q;

endmodule

// ----- hw/rtl/bvm_checker.sv -----
// Port-level checks for the battery voltage monitor, bound to the top level.
// Depends on bvm_pkg and battery_voltage_monitor_top.
module bvm_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [bvm_pkg::MV_W-1:0] average_mv,
	input logic                     warn,
	input logic                     sleep_request
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(average_mv))
		else $error("result changed while stalled");

	a_sleep_implies_warn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sleep_request |-> warn)
		else $error("sleep without warn");

	a_zero_mean_sleep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && average_mv == '0 |-> sleep_request && warn)
		else $error("zero mean without sleep");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second sample taken while first in work");

endmodule

bind battery_voltage_monitor_top bvm_checker u_bvm_checker (.*);
